>>> design/fpfr_pkg.sv
// fpfr_pkg: shared types and constants for the fifo page frame replacement block
// frame count, field widths, transfer structs, op codes and sequencer states
// no dependencies
`default_nettype none

package fpfr_pkg;

    localparam int FRAME_COUNT   = 8;
    localparam int PROCESS_COUNT = 64;
    localparam int PAGE_COUNT    = 16;

    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int KIND_W  = 2;
    localparam int PID_W   = 6;
    localparam int PAGE_W  = 4;
    localparam int FIDX_W  = 3;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_UNPIN   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  process_id;
        logic [PAGE_W-1:0] page_number;
    } in_item_t;

    typedef struct packed {
        logic              granted;
        logic [FIDX_W-1:0] frame_index;
        logic              evicted_valid;
        logic [PID_W-1:0]  evicted_process;
        logic [PAGE_W-1:0] evicted_page;
    } out_item_t;

    // sequencer to frame table
    typedef struct packed {
        logic              scan;
        logic              commit;
        logic              load;
        logic              release_op;
        logic              unpin;
        frame_t            step;
        frame_t            pos;
        logic              hit;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } ctl_t;

    // frame table to sequencer
    typedef struct packed {
        logic is_free;
        logic is_unpinned;
    } stat_t;

endpackage

`default_nettype wire

>>> design/fpfr_ctrl.sv
// fpfr_ctrl: sequencer that steps one frame per cycle and tracks the victim search
// holds the accepted item, the step counter and the first free / unpinned positions
// depends on fpfr_pkg
`default_nettype none

module fpfr_ctrl
    import fpfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    input  wire stat_t    stat,
    output logic          busy,
    output ctl_t          ctl
);

    localparam frame_t LAST = FRAME_W'(FRAME_COUNT - 1);

    state_t            state_reg, state_next;
    frame_t            step_reg, step_next;
    frame_t            free_pos_reg, free_pos_next;
    frame_t            unp_pos_reg, unp_pos_next;
    logic              free_found_reg, free_found_next;
    logic              unp_found_reg, unp_found_next;
    logic              load_reg, load_next;
    logic              release_reg, release_next;
    logic              unpin_reg, unpin_next;
    logic [PID_W-1:0]  pid_reg, pid_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              pid_ok;
    logic              page_ok;

    assign pid_ok  = int'(item.process_id) < PROCESS_COUNT;
    assign page_ok = int'(item.page_number) < PAGE_COUNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            free_found_reg <= 1'b0;
            unp_found_reg  <= 1'b0;
            load_reg       <= 1'b0;
            release_reg    <= 1'b0;
            unpin_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            free_found_reg <= free_found_next;
            unp_found_reg  <= unp_found_next;
            load_reg       <= load_next;
            release_reg    <= release_next;
            unpin_reg      <= unpin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_pos_reg <= free_pos_next;
        unp_pos_reg  <= unp_pos_next;
        pid_reg      <= pid_next;
        page_reg     <= page_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        free_pos_next   = free_pos_reg;
        unp_pos_next    = unp_pos_reg;
        free_found_next = free_found_reg;
        unp_found_next  = unp_found_reg;
        load_next       = load_reg;
        release_next    = release_reg;
        unpin_next      = unpin_reg;
        pid_next        = pid_reg;
        page_next       = page_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    step_next       = '0;
                    free_found_next = 1'b0;
                    unp_found_next  = 1'b0;
                    pid_next        = item.process_id;
                    page_next       = item.page_number;
                    load_next       = pid_ok && page_ok && (item.kind == KIND_LOAD);
                    release_next    = pid_ok && (item.kind == KIND_RELEASE);
                    unpin_next      = pid_ok && (item.kind == KIND_UNPIN);
                    if (load_next || release_next || unpin_next)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (load_reg)
                begin
                    if (stat.is_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_pos_next   = step_reg;
                    end
                    if (stat.is_unpinned && !unp_found_reg)
                    begin
                        unp_found_next = 1'b1;
                        unp_pos_next   = step_reg;
                    end
                end
                if (step_reg == LAST)
                    state_next = ST_COMMIT;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign ctl.scan       = (state_reg == ST_SCAN);
    assign ctl.commit     = (state_reg == ST_COMMIT);
    assign ctl.load       = load_reg;
    assign ctl.release_op = release_reg;
    assign ctl.unpin      = unpin_reg;
    assign ctl.step       = step_reg;
    assign ctl.pos        = free_found_reg ? free_pos_reg : unp_pos_reg;
    assign ctl.hit        = free_found_reg || unp_found_reg;
    assign ctl.pid        = pid_reg;
    assign ctl.page       = page_reg;

endmodule

`default_nettype wire

>>> design/fifo_page_frame_replacement.sv
// fifo page frame replacement: frame table, load order list and result register
// a valid item scans every frame in turn and then commits; an ignored item skips the
// scan and goes to commit with an all-zero result; the result register loads at commit
// no new item is taken until the last one commits; the scan takes one frame per cycle
// result strobe lasts one cycle, the receiver cannot stall
// reset: identity load order, all frames free and unpinned, no result pending
`default_nettype none

module fifo_page_frame_replacement
    import fpfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_item_t  item,
    output logic           busy,
    output logic           result_valid,
    output out_item_t      result
);

    ctl_t  ctl;
    stat_t stat;

    frame_t            order_reg [FRAME_COUNT];
    frame_t            order_next [FRAME_COUNT];
    logic              free_reg [FRAME_COUNT];
    logic              free_next [FRAME_COUNT];
    logic              pinned_reg [FRAME_COUNT];
    logic              pinned_next [FRAME_COUNT];
    logic [PID_W-1:0]  owner_reg [FRAME_COUNT];
    logic [PAGE_W-1:0] page_reg [FRAME_COUNT];

    frame_t    order_addr;
    frame_t    order_frame;
    frame_t    sel_frame;
    logic      owner_hit;
    logic      grant;
    out_item_t result_reg, result_next;
    logic      result_valid_reg;

    fpfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    // one frame lookup per cycle
    assign order_addr       = ctl.commit ? ctl.pos : ctl.step;
    assign order_frame      = order_reg[order_addr];
    assign sel_frame        = ctl.load ? order_frame : ctl.step;
    assign stat.is_free     = free_reg[sel_frame];
    assign stat.is_unpinned = !pinned_reg[sel_frame];
    assign owner_hit        = !free_reg[sel_frame] && (owner_reg[sel_frame] == ctl.pid);
    assign grant            = ctl.commit && ctl.load && ctl.hit;

    always_comb
    begin
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            order_next[i]  = order_reg[i];
            free_next[i]   = free_reg[i];
            pinned_next[i] = pinned_reg[i];
        end
        if (ctl.scan && owner_hit && ctl.release_op)
        begin
            free_next[sel_frame]   = 1'b1;
            pinned_next[sel_frame] = 1'b0;
        end
        if (ctl.scan && owner_hit && ctl.unpin)
            pinned_next[sel_frame] = 1'b0;
        if (grant)
        begin
            free_next[sel_frame]   = 1'b0;
            pinned_next[sel_frame] = 1'b1;
            // chosen frame moves to the tail
            for (int i = 0; i < FRAME_COUNT - 1; i++)
            begin
                if (FRAME_W'(i) >= ctl.pos)
                    order_next[i] = order_reg[i + 1];
            end
            order_next[FRAME_COUNT - 1] = order_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                order_reg[i]  <= FRAME_W'(i);
                free_reg[i]   <= 1'b1;
                pinned_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                order_reg[i]  <= order_next[i];
                free_reg[i]   <= free_next[i];
                pinned_reg[i] <= pinned_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grant)
        begin
            owner_reg[sel_frame] <= ctl.pid;
            page_reg[sel_frame]  <= ctl.page;
        end
    end

    always_comb
    begin
        result_next = '0;
        if (grant)
        begin
            result_next.granted     = 1'b1;
            result_next.frame_index = FIDX_W'(sel_frame);
            if (!free_reg[sel_frame])
            begin
                result_next.evicted_valid   = 1'b1;
                result_next.evicted_process = owner_reg[sel_frame];
                result_next.evicted_page    = page_reg[sel_frame];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= ctl.commit;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> bench/fifo_page_frame_replacement_tb.sv
// fifo_page_frame_replacement_tb: self-checking bench for the fifo page frame replacement block
// keeps its own frame table and load order list, predicts every result, checks each strobe
// depends on fpfr_pkg and fifo_page_frame_replacement

module fifo_page_frame_replacement_tb;
    import fpfr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_item_t item = '0;
    logic busy;
    logic result_valid;
    out_item_t result;

    // frame table mirror
    frame_t load_order [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] frame_free;
    logic [FRAME_COUNT-1:0] frame_pinned;
    logic [PID_W-1:0] frame_owner [FRAME_COUNT];
    logic [PAGE_W-1:0] frame_page [FRAME_COUNT];

    out_item_t pending_grants [$];
    out_item_t oldest_grant;
    int error_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b1;

    fifo_page_frame_replacement DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic out_item_t serve_request(input in_item_t req);
        out_item_t res;
        int pos;
        frame_t f;
        res = '0;
        pos = -1;
        if (int'(req.process_id) >= PROCESS_COUNT)
            return res;
        case (req.kind)
            KIND_LOAD:
            begin
                if (int'(req.page_number) >= PAGE_COUNT)
                    return res;
                for (int i = 0; i < FRAME_COUNT; i++)
                    if (pos < 0 && frame_free[load_order[i]])
                        pos = i;
                for (int i = 0; i < FRAME_COUNT; i++)
                    if (pos < 0 && !frame_pinned[load_order[i]])
                        pos = i;
                if (pos >= 0)
                begin
                    f = load_order[pos];
                    res.granted = 1'b1;
                    res.frame_index = f;
                    if (!frame_free[f])
                    begin
                        res.evicted_valid = 1'b1;
                        res.evicted_process = frame_owner[f];
                        res.evicted_page = frame_page[f];
                    end
                    for (int i = pos; i < FRAME_COUNT - 1; i++)
                        load_order[i] = load_order[i + 1];
                    load_order[FRAME_COUNT - 1] = f;
                    frame_free[f] = 1'b0;
                    frame_pinned[f] = 1'b1;
                    frame_owner[f] = req.process_id;
                    frame_page[f] = req.page_number;
                end
            end
            KIND_RELEASE:
            begin
                for (int i = 0; i < FRAME_COUNT; i++)
                    if (!frame_free[i] && frame_owner[i] == req.process_id)
                    begin
                        frame_free[i] = 1'b1;
                        frame_pinned[i] = 1'b0;
                        frame_owner[i] = '0;
                        frame_page[i] = '0;
                    end
            end
            KIND_UNPIN:
            begin
                for (int i = 0; i < FRAME_COUNT; i++)
                    if (!frame_free[i] && frame_owner[i] == req.process_id)
                        frame_pinned[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int random_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 65)
            return 0;
        else if (r < 93)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 40));
    endfunction

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one start transfer, prediction queued at the accepting edge
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid,
                                input logic [PAGE_W-1:0] page);
        in_item_t req;
        req.kind = kind;
        req.process_id = pid;
        req.page_number = page;
        start <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (busy);
        pending_grants.push_back(serve_request(req));
        if (gaps_on)
            idle_cycles(random_gap());
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %p", $time, result);
                error_count++;
            end
            else
            begin
                oldest_grant = pending_grants.pop_front();
                check_field("granted", 32'(oldest_grant.granted), 32'(result.granted));
                check_field("frame_index", 32'(oldest_grant.frame_index),
                            32'(result.frame_index));
                check_field("evicted_valid", 32'(oldest_grant.evicted_valid),
                            32'(result.evicted_valid));
                check_field("evicted_process", 32'(oldest_grant.evicted_process),
                            32'(result.evicted_process));
                check_field("evicted_page", 32'(oldest_grant.evicted_page),
                            32'(result.evicted_page));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // fill every frame from the free list, extremes of pid and page
    task automatic test_fill_frames();
        send_request(KIND_LOAD, 6'd0, 4'd0);
        send_request(KIND_LOAD, 6'd63, 4'd15);
        send_request(KIND_LOAD, 6'd10, 4'd3);
        send_request(KIND_LOAD, 6'd20, 4'd12);
        send_request(KIND_LOAD, 6'd10, 4'd5);
        send_request(KIND_LOAD, 6'd20, 4'd10);
        send_request(KIND_LOAD, 6'd42, 4'd7);
        send_request(KIND_LOAD, 6'd21, 4'd8);
    endtask

    // every frame bound and pinned
    task automatic test_no_frame();
        send_request(KIND_LOAD, 6'd5, 4'd5);
    endtask

    task automatic test_unpin_evict();
        send_request(KIND_UNPIN, 6'd10, 4'd15);
        send_request(KIND_LOAD, 6'd7, 4'd9);
    endtask

    task automatic test_release();
        send_request(KIND_RELEASE, 6'd20, 4'd0);
        send_request(KIND_LOAD, 6'd33, 4'd1);
        send_request(KIND_LOAD, 6'd34, 4'd2);
    endtask

    task automatic test_reserved_kind();
        send_request(KIND_RESERVED, 6'd63, 4'd15);
    endtask

    // same page faulted twice lands in two frames
    task automatic test_repeat_load();
        send_request(KIND_UNPIN, 6'd0, 4'd0);
        send_request(KIND_UNPIN, 6'd63, 4'd0);
        send_request(KIND_LOAD, 6'd63, 4'd15);
        send_request(KIND_LOAD, 6'd63, 4'd15);
    endtask

    task automatic test_random_traffic();
        logic [PID_W-1:0] pid_pool [6];
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0] pid;
        int r;
        for (int blk = 0; blk < 14; blk++)
        begin
            gaps_on = (blk % 4) != 3;
            foreach (pid_pool[j])
                pid_pool[j] = PID_W'($urandom_range(0, 63));
            for (int n = 0; n < 100; n++)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 62)
                    kind = KIND_LOAD;
                else if (r < 77)
                    kind = KIND_UNPIN;
                else if (r < 90)
                    kind = KIND_RELEASE;
                else
                    kind = KIND_RESERVED;
                if ($urandom_range(0, 99) < 85)
                    pid = pid_pool[$urandom_range(0, 5)];
                else
                    pid = PID_W'($urandom_range(0, 63));
                send_request(kind, pid, PAGE_W'($urandom_range(0, 15)));
                if ($urandom_range(0, 199) == 0)
                    wait_all_results();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            load_order[i] = frame_t'(i);
            frame_owner[i] = '0;
            frame_page[i] = '0;
        end
        frame_free = '1;
        frame_pinned = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_frames();
        test_no_frame();
        test_unpin_evict();
        test_release();
        test_reserved_kind();
        test_repeat_load();
        wait_all_results();
        test_random_traffic();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
